FILE: rtl/qwc_pkg.sv
// types and constants shared by the quality window clipper
`timescale 1ns / 1ps
`default_nettype none
package qwc_pkg;

	typedef struct packed {
		logic [6:0] quality;
		logic       last_base;
	} in_word_t;

	typedef struct packed {
		logic [12:0] left_clip;
		logic [12:0] right_clip;
		logic [1:0]  clip_status;
	} out_word_t;

	typedef enum logic [2:0] {
		REG_THRESHOLD  = 3'd0,
		REG_WINDOW     = 3'd1,
		REG_MIN_LEFT   = 3'd2,
		REG_MAX_RIGHT  = 3'd3,
		REG_MIN_KEPT   = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_SUM,
		ST_RDA,
		ST_RDB,
		ST_UPD,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_BEST,
		PH_LEFT,
		PH_RIGHT
	} phase_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_ALL_ZERO = 2'd2;

	localparam logic [6:0]  RST_THRESHOLD = 7'd10;
	localparam logic [7:0]  RST_WINDOW    = 8'd30;
	localparam logic [12:0] RST_MIN_LEFT  = 13'd0;
	localparam logic [12:0] RST_MAX_RIGHT = 13'd4098;
	localparam logic [12:0] RST_MIN_KEPT  = 13'd0;

endpackage
`default_nettype wire

FILE: rtl/qwc_store.sv
// quality store: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none
module qwc_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [6:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [6:0]         rdata
);

	logic [6:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/quality_window_clip_core.sv
// quality window clipper top level: config registers, scan sequencer, result register
//
// Takes one base quality per cycle until the word marked last_base, then stalls
// input while it searches the store: the best-window search sums a window and steps
// it along the read (L bases loaded, W the window length; L/2 is taken directly
// when W >= L), and each of the W passes of the left and right scans does the same,
// each step reading the single read port of the quality store twice. ST_FIN and
// ST_DONE clamp the clip points. The result waits in an output register while the
// next read loads. Bases past MAX_READ_LEN are dropped; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module quality_window_clip_core #(
	parameter int MAX_READ_LEN = 4096
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire qwc_pkg::in_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output qwc_pkg::out_word_t     out_word,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	import qwc_pkg::*;

	localparam int AW = $clog2(MAX_READ_LEN);
	localparam int CW = $clog2(MAX_READ_LEN + 1);
	localparam int PW = ((CW > 13) ? CW : 13) + 2;

	// configuration
	logic [6:0]  thr_q;
	logic [7:0]  win_q;
	logic [12:0] min_left_q;
	logic [12:0] max_right_q;
	logic [12:0] min_kept_q;
	logic        cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= RST_THRESHOLD;
			win_q       <= RST_WINDOW;
			min_left_q  <= RST_MIN_LEFT;
			max_right_q <= RST_MAX_RIGHT;
			min_kept_q  <= RST_MIN_KEPT;
		end else if (cfg_we) begin
			unique case (paddr[4:2])
				REG_THRESHOLD: thr_q       <= pwdata[6:0];
				REG_WINDOW:    win_q       <= pwdata[7:0];
				REG_MIN_LEFT:  min_left_q  <= pwdata[12:0];
				REG_MAX_RIGHT: max_right_q <= pwdata[12:0];
				REG_MIN_KEPT:  min_kept_q  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			REG_THRESHOLD: prdata = {25'd0, thr_q};
			REG_WINDOW:    prdata = {24'd0, win_q};
			REG_MIN_LEFT:  prdata = {19'd0, min_left_q};
			REG_MAX_RIGHT: prdata = {19'd0, max_right_q};
			REG_MIN_KEPT:  prdata = {19'd0, min_kept_q};
			default:       prdata = '0;
		endcase
	end

	// sequencer state
	state_t state_q, state_d;
	phase_t phase_q;

	logic [CW-1:0]        count_q;
	logic                 any_nz_q;
	logic signed [PW-1:0] k_q, base_q, start_q, pos_q, left_res_q, right_res_q;
	logic signed [PW-1:0] left_q, right_q;
	logic [7:0]           w_cur_q, cnt_q;
	logic [15:0]          sum_q, best_q;
	logic [14:0]          floor_q;
	logic [6:0]           qsub_q;
	logic                 rd_en_s1, rd_ok_s1;
	out_word_t            out_word_q;
	logic                 out_valid_q;

	logic                 in_acc, out_free;
	logic signed [PW-1:0] len_s, win_s, wcur_s;
	logic signed [PW-1:0] add_idx, sub_idx, k_n, rd_idx;
	logic                 rd_en, rd_ok;
	logic [6:0]           rdata, qv;
	logic [15:0]          sum_n;
	logic                 sum_done, better, keep_going, last_pass, ge_floor;
	logic signed [PW-1:0] start_n, l_fin, r_fin, l2, l3;
	logic                 short_fl;
	out_word_t            res_word;

	assign len_s  = $signed({{(PW-CW){1'b0}}, count_q});
	assign win_s  = $signed({{(PW-8){1'b0}}, win_q});
	assign wcur_s = $signed({{(PW-8){1'b0}}, w_cur_q});

	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign qv       = rd_ok_s1 ? rdata : 7'd0;

	// left scan steps the window down, the others step it up
	always_comb begin
		if (phase_q == PH_LEFT) begin
			k_n     = k_q - PW'(1);
			add_idx = k_q - PW'(1);
			sub_idx = k_q - PW'(1) + wcur_s;
		end else begin
			k_n     = k_q + PW'(1);
			add_idx = k_q + wcur_s;
			sub_idx = k_q;
		end
	end

	assign sum_n     = sum_q + {9'd0, qv} - {9'd0, qsub_q};
	assign sum_done  = (cnt_q == w_cur_q) && !rd_en_s1;
	assign better    = sum_n > best_q;
	assign ge_floor  = sum_n >= {1'b0, floor_q};
	assign last_pass = w_cur_q <= 8'd1;
	assign start_n   = (better ? k_q : pos_q) + PW'(1);

	always_comb begin
		case (phase_q)
			PH_BEST:  keep_going = k_n < (len_s - win_s);
			PH_LEFT:  keep_going = (k_n > PW'(0)) && ge_floor;
			default:  keep_going = (k_n <= (len_s - wcur_s - PW'(1))) && ge_floor;
		endcase
	end

	// store read port
	always_comb begin
		rd_en  = 1'b0;
		rd_idx = base_q + $signed({{(PW-8){1'b0}}, cnt_q});
		case (state_q)
			ST_SUM: rd_en = cnt_q < w_cur_q;
			ST_RDA: begin
				rd_en  = 1'b1;
				rd_idx = sub_idx;
			end
			ST_RDB: begin
				rd_en  = 1'b1;
				rd_idx = add_idx;
			end
			default: ;
		endcase
		rd_ok = rd_en && (rd_idx >= PW'(0)) && (rd_idx < len_s);
	end

	qwc_store #(
		.DEPTH(MAX_READ_LEN),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (in_acc && (count_q < CW'(MAX_READ_LEN))),
		.waddr(count_q[AW-1:0]),
		.wdata(in_word.quality),
		.re   (rd_ok),
		.raddr(rd_idx[AW-1:0]),
		.rdata(rdata)
	);

	// final clamping, second half
	always_comb begin
		l2       = (left_q >= right_q) ? right_q - PW'(1) : left_q;
		short_fl = (right_q - l2) < $signed({{(PW-13){1'b0}}, min_kept_q});
		l3       = (l2 < PW'(0)) ? PW'(0) : l2;
		if (!any_nz_q) begin
			res_word.left_clip   = '0;
			res_word.right_clip  = '0;
			res_word.clip_status = STATUS_ALL_ZERO;
		end else begin
			res_word.left_clip   = l3[12:0];
			res_word.right_clip  = right_q[12:0];
			res_word.clip_status = short_fl ? STATUS_SHORT : STATUS_OK;
		end
	end

	always_comb begin
		l_fin = left_res_q + PW'(1);
		if (l_fin < $signed({{(PW-13){1'b0}}, min_left_q})) begin
			l_fin = $signed({{(PW-13){1'b0}}, min_left_q});
		end
		r_fin = right_res_q + PW'(1);
		if (r_fin > $signed({{(PW-13){1'b0}}, max_right_q})) begin
			r_fin = $signed({{(PW-13){1'b0}}, max_right_q});
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_acc && in_word.last_base) state_d = ST_START;
			ST_START: state_d = any_nz_q ? ST_SUM : ST_DONE;
			ST_SUM:   if (sum_done) state_d = ST_RDA;
			ST_RDA:   state_d = ST_RDB;
			ST_RDB:   state_d = ST_UPD;
			ST_UPD: begin
				if (keep_going) begin
					state_d = ST_RDA;
				end else if (phase_q == PH_RIGHT && last_pass) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SUM;
				end
			end
			ST_FIN:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_stall  = state_q != ST_LOAD;
		out_valid = out_valid_q;
		out_word  = out_word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			any_nz_q    <= 1'b0;
			out_valid_q <= 1'b0;
			rd_en_s1    <= 1'b0;
			rd_ok_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_en_s1 <= rd_en;
			rd_ok_s1 <= rd_ok;
			if (state_q == ST_LOAD && in_acc && count_q < CW'(MAX_READ_LEN)) begin
				count_q <= count_q + CW'(1);
				if (in_word.quality != 7'd0) begin
					any_nz_q <= 1'b1;
				end
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				any_nz_q    <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				cnt_q   <= '0;
				sum_q   <= '0;
				w_cur_q <= win_q;
				if (win_s >= len_s) begin
					phase_q <= PH_LEFT;
					base_q  <= len_s >>> 1;
					start_q <= len_s >>> 1;
				end else begin
					phase_q <= PH_BEST;
					base_q  <= '0;
				end
			end
			ST_SUM: begin
				floor_q <= 15'(thr_q * w_cur_q);
				if (rd_en) cnt_q <= cnt_q + 8'd1;
				if (rd_en_s1) sum_q <= sum_q + {9'd0, qv};
				if (sum_done) begin
					k_q <= base_q;
					if (phase_q == PH_BEST) begin
						best_q <= sum_q;
						pos_q  <= '0;
					end
				end
			end
			ST_RDB: qsub_q <= qv;
			ST_UPD: begin
				sum_q <= sum_n;
				k_q   <= k_n;
				cnt_q <= '0;
				if (phase_q == PH_BEST) begin
					if (better) begin
						best_q <= sum_n;
						pos_q  <= k_q;
					end
					if (!keep_going) begin
						phase_q <= PH_LEFT;
						base_q  <= start_n;
						start_q <= start_n;
						w_cur_q <= win_q;
						sum_q   <= '0;
					end
				end else if (!keep_going) begin
					sum_q <= '0;
					if (last_pass) begin
						w_cur_q <= win_q;
						if (phase_q == PH_LEFT) begin
							left_res_q <= k_n;
							phase_q    <= PH_RIGHT;
							base_q     <= start_q;
						end else begin
							right_res_q <= (k_n == len_s) ? len_s + PW'(1) : k_n;
						end
					end else begin
						w_cur_q <= w_cur_q - 8'd1;
						base_q  <= (phase_q == PH_LEFT) ? k_n + PW'(2) : k_n - PW'(1);
					end
				end
			end
			ST_FIN: begin
				left_q  <= l_fin;
				right_q <= r_fin;
			end
			ST_DONE: if (out_free) out_word_q <= res_word;
			default: ;
		endcase
	end

endmodule
`default_nettype wire
